// File: design/cmpd_pkg.sv
`default_nettype none
package cmpd_pkg;

   localparam int CODE_BITS = 15;
   localparam int SYM_BITS  = 8;
   localparam int LEN_BITS  = 4;
   localparam int ROW_AW    = 2 * SYM_BITS;

   // Input actions
   typedef enum logic [1:0] {
      ACT_RESTART = 2'd0,
      ACT_LOAD    = 2'd1,
      ACT_DECODE  = 2'd2
   } action_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_PICK,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_FRONT,
      ST_EMIT
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic clear_start;
      logic clear_en;
      logic load_en;
      logic lookup_en;
      logic keep_bits;
      logic code_restart;
      logic pick_rd;
      logic pick_take;
      logic shift_rd;
      logic shift_wr;
      logic front_wr;
      logic set_res_sym;
      logic set_res_err;
      logic set_res_pick;
      logic emit_en;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic clear_done;
      logic match;
      logic full;
      logic mode;
      logic k_zero;
      logic k_one;
      logic out_free;
   } stat_type;

endpackage
`default_nettype wire

// File: design/cmpd_ctrl.sv
`default_nettype none
module cmpd_ctrl
   import cmpd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic [1:0]  req_action,
   output logic             req_tready,
   input  wire stat_type    stat,
   output cmd_type          cmd
);

   state_type state_ff, state_in;
   logic      accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   // Advance state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (stat.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (req_action)
                  ACT_RESTART: state_in = ST_CLEAR;
                  ACT_DECODE:  state_in = ST_LOOKUP;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_LOOKUP: begin
            priority if (stat.match && stat.mode) state_in = ST_EMIT;
            else if (stat.match)                  state_in = ST_PICK;
            else if (stat.full)                   state_in = ST_EMIT;
            else                                  state_in = ST_IDLE;
         end
         ST_PICK: begin
            state_in = stat.k_zero ? ST_FRONT : ST_SHIFT_RD;
         end
         ST_SHIFT_RD: state_in = ST_SHIFT_WR;
         ST_SHIFT_WR: begin
            state_in = stat.k_one ? ST_FRONT : ST_SHIFT_RD;
         end
         ST_FRONT: state_in = ST_EMIT;
         ST_EMIT: begin
            if (stat.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // Commands
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_CLEAR: cmd.clear_en = 1'b1;
         ST_IDLE: begin
            if (accept) begin
               unique case (req_action)
                  ACT_RESTART: cmd.clear_start = 1'b1;
                  ACT_LOAD:    cmd.load_en     = 1'b1;
                  ACT_DECODE:  cmd.lookup_en   = 1'b1;
                  default:     ;
               endcase
            end
         end
         ST_LOOKUP: begin
            priority if (stat.match) begin
               cmd.code_restart = 1'b1;
               cmd.set_res_sym  = stat.mode;
               cmd.pick_rd      = !stat.mode;
            end else if (stat.full) begin
               cmd.code_restart = 1'b1;
               cmd.set_res_err  = 1'b1;
            end else begin
               cmd.keep_bits = 1'b1;
            end
         end
         ST_PICK:     cmd.pick_take = 1'b1;
         ST_SHIFT_RD: cmd.shift_rd  = 1'b1;
         ST_SHIFT_WR: cmd.shift_wr  = 1'b1;
         ST_FRONT: begin
            cmd.front_wr     = 1'b1;
            cmd.set_res_pick = 1'b1;
         end
         ST_EMIT: cmd.emit_en = stat.out_free;
         default: ;
      endcase
   end

endmodule
`default_nettype wire

// File: design/cmpd_path.sv
`default_nettype none
module cmpd_path
   import cmpd_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cmd_type              cmd,
   output stat_type                  stat,
   input  wire logic [SYM_BITS-1:0]  req_symbol,
   input  wire logic [LEN_BITS-1:0]  req_code_length,
   input  wire logic [CODE_BITS-1:0] req_code_value,
   input  wire logic                 req_code_bit,
   input  wire logic [SYM_BITS-1:0]  req_context_byte,
   input  wire logic                 csr_we,
   input  wire logic                 csr_wdata,
   input  wire logic                 rsp_tready,
   output logic                      rsp_tvalid,
   output logic [SYM_BITS-1:0]       rsp_value,
   output logic                      rsp_error
);

   localparam int SLOT_W = LEN_BITS + SYM_BITS;

   logic [SLOT_W-1:0]    slot_mem [2**CODE_BITS];
   logic [SYM_BITS-1:0]  row_mem  [2**ROW_AW];

   logic                 mode_ff;
   logic [CODE_BITS-1:0] partial_ff;
   logic [LEN_BITS-1:0]  bits_ff, n_ff;
   logic [SYM_BITS-1:0]  ctx_ff, k_ff, picked_ff, row_rd_ff;
   logic [SLOT_W-1:0]    slot_rd_ff;
   logic [ROW_AW-1:0]    clr_cnt_ff;
   logic [SYM_BITS-1:0]  res_value_ff, out_value_ff;
   logic                 res_error_ff, out_error_ff, out_valid_ff;

   logic [LEN_BITS-1:0]  n_in;
   logic [CODE_BITS-1:0] bit_mask, partial_in, load_addr;
   logic [LEN_BITS-1:0]  slot_len_rd;
   logic [SYM_BITS-1:0]  slot_sym_rd;
   logic                 slot_we;
   logic [CODE_BITS-1:0] slot_waddr;
   logic [SLOT_W-1:0]    slot_wdata;
   logic                 row_we;
   logic [ROW_AW-1:0]    row_waddr, row_raddr;
   logic [SYM_BITS-1:0]  row_wdata, clr_row, clr_entry;

   // Gather one more code bit, first bit at the top
   assign n_in       = bits_ff + LEN_BITS'(1);
   assign bit_mask   = CODE_BITS'(1) << (LEN_BITS'(CODE_BITS) - n_in);
   assign partial_in = req_code_bit ? (partial_ff | bit_mask) : partial_ff;
   assign load_addr  = req_code_value << (LEN_BITS'(CODE_BITS) - req_code_length);

   assign slot_len_rd = slot_rd_ff[SLOT_W-1:SYM_BITS];
   assign slot_sym_rd = slot_rd_ff[SYM_BITS-1:0];

   // Slot memory port select
   always_comb begin
      slot_we    = cmd.clear_en || (cmd.load_en && (req_code_length != '0));
      slot_waddr = cmd.clear_en ? clr_cnt_ff[CODE_BITS-1:0] : load_addr;
      slot_wdata = cmd.clear_en ? '0 : {req_code_length, req_symbol};
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_waddr] <= slot_wdata;
      end
   end

   always_ff @(posedge clock) begin
      slot_rd_ff <= slot_mem[partial_in];
   end

   // Row memory port select
   assign clr_row   = clr_cnt_ff[ROW_AW-1:SYM_BITS];
   assign clr_entry = clr_cnt_ff[SYM_BITS-1:0];

   always_comb begin
      row_raddr = cmd.pick_rd ? {ctx_ff, slot_sym_rd} : {ctx_ff, k_ff - SYM_BITS'(1)};
      row_we    = cmd.clear_en || cmd.shift_wr || cmd.front_wr;
      priority if (cmd.clear_en) begin
         row_waddr = clr_cnt_ff;
         row_wdata = SYM_BITS'(8'hFF) - clr_row - clr_entry;
      end else if (cmd.shift_wr) begin
         row_waddr = {ctx_ff, k_ff};
         row_wdata = row_rd_ff;
      end else begin
         row_waddr = {ctx_ff, SYM_BITS'(0)};
         row_wdata = picked_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (row_we) begin
         row_mem[row_waddr] <= row_wdata;
      end
   end

   always_ff @(posedge clock) begin
      row_rd_ff <= row_mem[row_raddr];
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 1'b0;
         partial_ff   <= '0;
         bits_ff      <= '0;
         clr_cnt_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_we) mode_ff <= csr_wdata;
         priority if (cmd.clear_start || cmd.code_restart) begin
            partial_ff <= '0;
            bits_ff    <= '0;
         end else if (cmd.lookup_en) begin
            partial_ff <= partial_in;
         end else if (cmd.keep_bits) begin
            bits_ff <= n_ff;
         end
         priority if (cmd.clear_start) clr_cnt_ff <= '0;
         else if (cmd.clear_en)        clr_cnt_ff <= clr_cnt_ff + ROW_AW'(1);
         priority if (cmd.emit_en) out_valid_ff <= 1'b1;
         else if (rsp_tready)      out_valid_ff <= 1'b0;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.lookup_en) begin
         n_ff   <= n_in;
         ctx_ff <= req_context_byte;
      end
      if (cmd.pick_rd)   k_ff <= slot_sym_rd;
      if (cmd.shift_wr)  k_ff <= k_ff - SYM_BITS'(1);
      if (cmd.pick_take) picked_ff <= row_rd_ff;
      priority if (cmd.set_res_sym) begin
         res_value_ff <= slot_sym_rd;
         res_error_ff <= 1'b0;
      end else if (cmd.set_res_err) begin
         res_value_ff <= '0;
         res_error_ff <= 1'b1;
      end else if (cmd.set_res_pick) begin
         res_value_ff <= picked_ff;
         res_error_ff <= 1'b0;
      end
      if (cmd.emit_en) begin
         out_value_ff <= res_value_ff;
         out_error_ff <= res_error_ff;
      end
   end

   always_comb begin
      stat.clear_done = (clr_cnt_ff == '1);
      stat.match      = ({1'b0, slot_len_rd} == {1'b0, n_ff});
      stat.full       = (n_ff == LEN_BITS'(CODE_BITS));
      stat.mode       = mode_ff;
      stat.k_zero     = (k_ff == '0);
      stat.k_one      = (k_ff == SYM_BITS'(1));
      stat.out_free   = !out_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_value  = out_value_ff;
   assign rsp_error  = out_error_ff;

endmodule
`default_nettype wire

// File: design/context_mtf_prefix_decoder_top.sv
`default_nettype none
// Channel | Ports                  | Contents
// req     | req_tvalid/tready      | tuser: action; tdata: symbol, code_length,
//         |                        |   code_value, code_bit, context_byte
// rsp     | rsp_tvalid/tready      | tuser: error; tdata: value
// csr     | csr_we, csr_wdata      | mode
// A load item is taken in IDLE; a decode bit without result passes LOOKUP.
// A completed code goes straight from LOOKUP to EMIT in direct mode. In
// move-to-front mode it passes PICK, then a SHIFT_RD and a SHIFT_WR state per
// row byte moved in the rank memory, then FRONT, before EMIT.
// Reset and restart run a clearing pass over all 65536 rank-row entries (code
// slots cleared alongside); no item is taken meanwhile.
// A held result stalls only a later transaction that produces one.
module context_mtf_prefix_decoder_top
   import cmpd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [7:0] symbol, [11:8] code_length, [26:12] code_value, [27] code_bit,
   // [35:28] context_byte, [39:36] zero
   input  wire logic [39:0] req_tdata,
   // [1:0] action
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [7:0] value
   output logic [7:0]       rsp_tdata,
   // [0] error
   output logic [0:0]       rsp_tuser,
   input  wire logic        csr_we,
   input  wire logic [0:0]  csr_wdata
);

   cmd_type  cmd;
   stat_type stat;

   cmpd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_action (req_tuser),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   cmpd_path u_path (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_symbol       (req_tdata[7:0]),
      .req_code_length  (req_tdata[11:8]),
      .req_code_value   (req_tdata[26:12]),
      .req_code_bit     (req_tdata[27]),
      .req_context_byte (req_tdata[35:28]),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata[0]),
      .rsp_tready       (rsp_tready),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_value        (rsp_tdata),
      .rsp_error        (rsp_tuser[0])
   );

endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
module testbench;
   import cmpd_pkg::*;

   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam int LIMIT_CYCLES = 4000000;
   localparam int SETTLE_CYCLES = 700;
   localparam int HOLD_CYCLES = 3000;
   localparam int HOLD_AFTER = 20;

   typedef struct {
      logic [1:0]  action;
      logic [7:0]  symbol;
      logic [3:0]  code_length;
      logic [14:0] code_value;
      logic        code_bit;
      logic [7:0]  context_byte;
   } bit_item_type;

   typedef struct {
      logic [7:0] value;
      logic       error;
   } byte_out_type;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [39:0] req_tdata;
   logic [1:0] req_tuser;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [7:0] rsp_tdata;
   logic [0:0] rsp_tuser;
   logic csr_we;
   logic [0:0] csr_wdata;

   // predictor state
   logic [3:0] slot_len [0:32767];
   logic [7:0] slot_sym [0:32767];
   logic [7:0] rank_row [0:65535];
   logic [14:0] gathered;
   int unsigned gathered_n;
   logic cur_mode;

   bit_item_type pending_items[$];
   byte_out_type expected_bytes[$];
   bit_item_type drv_item;
   int fail_count = 0;
   int rsp_count = 0;
   int err_count = 0;
   int unsigned cycle_count = 0;
   int unsigned hold_left = 0;
   bit hold_done = 0;
   bit quiet = 0;

   // code tree used by the random part
   logic [14:0] leaf_code [0:63];
   int unsigned leaf_len [0:63];
   int leaf_count;

   context_mtf_prefix_decoder_top uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   function automatic void clear_tables();
      for (int s = 0; s < 32768; s++) begin
         slot_len[s] = 0;
         slot_sym[s] = 0;
      end
      for (int r = 0; r < 256; r++)
         for (int e = 0; e < 256; e++)
            rank_row[r * 256 + e] = 8'(255 - r - e);
      gathered = 0;
      gathered_n = 0;
   endfunction

   // compute the result, if any, of one accepted transaction
   function automatic void predict_byte(bit_item_type it);
      int unsigned n;
      int unsigned slot;
      int unsigned base;
      int k;
      logic [7:0] picked;
      byte_out_type res;
      case (it.action)
         ACT_RESTART: clear_tables();
         ACT_LOAD: begin
            if (it.code_length != 0) begin
               slot = (32'(it.code_value) << (15 - it.code_length)) & 32'h7FFF;
               slot_len[slot] = it.code_length;
               slot_sym[slot] = it.symbol;
            end
         end
         ACT_DECODE: begin
            n = gathered_n + 1;
            if (it.code_bit) gathered = gathered | 15'(1 << (15 - n));
            if (32'(slot_len[gathered]) == n) begin
               if (cur_mode) begin
                  res.value = slot_sym[gathered];
               end else begin
                  base = 32'(it.context_byte) * 256;
                  k = slot_sym[gathered];
                  picked = rank_row[base + k];
                  for (; k > 0; k--) rank_row[base + k] = rank_row[base + k - 1];
                  rank_row[base] = picked;
                  res.value = picked;
               end
               res.error = 0;
               expected_bytes.push_back(res);
               gathered = 0;
               gathered_n = 0;
            end else if (n >= 15) begin
               res.value = 0;
               res.error = 1;
               expected_bytes.push_back(res);
               gathered = 0;
               gathered_n = 0;
            end else begin
               gathered_n = n;
            end
         end
         default: ;
      endcase
   endfunction

   // drive request transactions from the pending queue
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 0;
      end else begin
         if (req_tvalid && req_tready) predict_byte(drv_item);
         if (!req_tvalid || req_tready) begin
            if (pending_items.size() > 0 && (quiet || $urandom_range(99) >= 13)) begin
               drv_item = pending_items.pop_front();
               req_tvalid <= 1;
               req_tuser <= drv_item.action;
               req_tdata <= {4'b0, drv_item.context_byte, drv_item.code_bit,
                             drv_item.code_value, drv_item.code_length, drv_item.symbol};
            end else begin
               req_tvalid <= 0;
            end
         end
      end
   end

   // check result transactions against the oldest expected byte
   always @(posedge clock) begin
      byte_out_type want;
      if (reset) begin
         rsp_tready <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_count++;
            if (rsp_tuser[0]) err_count++;
            if (expected_bytes.size() == 0) begin
               $error("unexpected result: value %0d error %0d", rsp_tdata, rsp_tuser[0]);
               fail_count++;
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_tdata !== want.value) begin
                  $error("value: expected %0d, got %0d", want.value, rsp_tdata);
                  fail_count++;
               end
               if (rsp_tuser[0] !== want.error) begin
                  $error("error: expected %0d, got %0d", want.error, rsp_tuser[0]);
                  fail_count++;
               end
            end
            if (rsp_count == HOLD_AFTER && !hold_done) begin
               hold_left = HOLD_CYCLES;
               hold_done = 1;
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 0;
         end else begin
            rsp_tready <= quiet || ($urandom_range(99) >= 13);
         end
      end
   end

   // bound the run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic push_item(logic [1:0] act, logic [7:0] sym, logic [3:0] len,
                            logic [14:0] code, logic b, logic [7:0] ctx);
      bit_item_type it;
      it.action = act;
      it.symbol = sym;
      it.code_length = len;
      it.code_value = code;
      it.code_bit = b;
      it.context_byte = ctx;
      pending_items.push_back(it);
   endtask

   task automatic push_code_bits(logic [14:0] code, int unsigned len, logic [7:0] ctx);
      for (int b = int'(len) - 1; b >= 0; b--)
         push_item(ACT_DECODE, 8'($urandom), 4'($urandom), 15'($urandom), code[b], ctx);
   endtask

   // wait for the block to drain, then write the mode register
   task automatic write_mode(logic m);
      while (pending_items.size() > 0 || req_tvalid || expected_bytes.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we <= 1;
      csr_wdata <= m;
      cur_mode = m;
      @(posedge clock);
      csr_we <= 0;
   endtask

   // build a random prefix code, load it, then stream mostly valid codes
   task automatic random_phase(int count, bit do_restart);
      int idx;
      int target;
      bit deep;
      int made;
      logic [14:0] upper;
      if (do_restart) push_item(ACT_RESTART, 0, 0, 0, 0, 0);
      leaf_code[0] = 0;
      leaf_len[0] = 0;
      leaf_count = 1;
      target = $urandom_range(2, 24);
      deep = ($urandom_range(3) == 0);
      idx = 0;
      while (leaf_count < target) begin
         if (!deep) idx = $urandom_range(leaf_count - 1);
         if (leaf_len[idx] < 15) begin
            leaf_len[idx]++;
            leaf_code[idx] = leaf_code[idx] << 1;
            leaf_code[leaf_count] = leaf_code[idx] | 15'd1;
            leaf_len[leaf_count] = leaf_len[idx];
            leaf_count++;
         end else begin
            deep = 0;
         end
      end
      for (int i = 0; i < leaf_count; i++) begin
         if ($urandom_range(9) != 0) begin
            upper = 15'($urandom) << leaf_len[i];
            push_item(ACT_LOAD, 8'($urandom), 4'(leaf_len[i]),
                      leaf_code[i] | upper, $urandom_range(1), 8'($urandom));
         end
      end
      made = 0;
      while (made < count) begin
         case ($urandom_range(9))
            0: push_item(ACT_DECODE, 8'($urandom), 4'($urandom), 15'($urandom),
                         $urandom_range(1), 8'($urandom));
            1: push_item(ACT_UNUSED, 8'($urandom), 4'($urandom), 15'($urandom),
                         $urandom_range(1), 8'($urandom));
            2: push_item(ACT_LOAD, 8'($urandom), 4'($urandom_range(1) ? 0 : $urandom),
                         15'($urandom), $urandom_range(1), 8'($urandom));
            default: begin
               idx = $urandom_range(leaf_count - 1);
               push_code_bits(leaf_code[idx], leaf_len[idx], 8'($urandom));
               made += int'(leaf_len[idx]) - 1;
            end
         endcase
         made++;
      end
   endtask

   initial begin
      reset = 1;
      req_tvalid = 0;
      req_tdata = 0;
      req_tuser = 0;
      rsp_tready = 0;
      csr_we = 0;
      csr_wdata = 0;
      cur_mode = 0;
      clear_tables();
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      csr_we <= 1;
      csr_wdata <= 0;
      @(posedge clock);
      csr_we <= 0;

      // directed: unused action, zero length, extreme codes, no match, restart
      push_item(ACT_UNUSED, 8'hFF, 4'hF, 15'h7FFF, 1, 8'hFF);
      push_item(ACT_LOAD, 8'd7, 4'd0, 15'h7FFF, 1, 8'hFF);
      push_item(ACT_LOAD, 8'd0, 4'd1, 15'h7FFE, 0, 8'h00);
      push_item(ACT_LOAD, 8'd255, 4'd15, 15'h7FFF, 1, 8'hFF);
      push_item(ACT_DECODE, 0, 0, 0, 0, 8'h00);
      push_code_bits(15'h7FFF, 15, 8'hFF);
      push_code_bits(15'h7FFF, 15, 8'h00);
      push_code_bits(15'h4000, 15, 8'h80);
      push_item(ACT_DECODE, 0, 0, 0, 1, 8'h01);
      push_item(ACT_LOAD, 8'd3, 4'd2, 15'h0002, 0, 0);
      push_item(ACT_DECODE, 0, 0, 0, 0, 8'hFF);
      push_item(ACT_RESTART, 8'hFF, 4'hF, 15'h7FFF, 1, 8'hFF);
      push_code_bits(15'h0000, 15, 8'h55);
      write_mode(1);
      push_item(ACT_LOAD, 8'd255, 4'd1, 15'h0001, 0, 0);
      push_item(ACT_DECODE, 0, 0, 0, 1, 8'h33);

      quiet = 1;
      random_phase(120, 0);
      write_mode(1);
      quiet = 0;
      write_mode(0);
      random_phase(120, 1);
      write_mode(1);
      random_phase(120, 0);
      write_mode(0);
      random_phase(120, 1);
      write_mode(1);
      random_phase(80, 0);

      while (pending_items.size() > 0 || req_tvalid || expected_bytes.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Covered loads, restarts, unused actions and decodes in both modes:");
      $display("%0d results checked, %0d of them no-match errors", rsp_count, err_count);
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end
endmodule

// File: files.f
design/cmpd_pkg.sv
design/cmpd_ctrl.sv
design/cmpd_path.sv
design/context_mtf_prefix_decoder_top.sv
tb/sv/testbench.sv
